// File: sv/qcd_pkg.sv
// ----------------------------------------------------------------------------
// QPSK coherent demodulator package
// Widths, carrier tables and shared types for the demodulator datapath.
// ----------------------------------------------------------------------------
package qcd_pkg;

   localparam int SYMBOL_CYCLES = 4;
   localparam int SAMPLE_WIDTH  = 16;

   localparam int COEF_WIDTH   = 16;
   localparam int PHASE_WIDTH  = 3;
   localparam int SYMBOL_LEN   = 8 * SYMBOL_CYCLES;
   localparam int POS_WIDTH    = $clog2(SYMBOL_LEN);
   localparam int PROD_WIDTH   = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int ACC_WIDTH    = PROD_WIDTH + POS_WIDTH;
   localparam int THRESH_WIDTH = 36;
   localparam int CMP_WIDTH    = (ACC_WIDTH > THRESH_WIDTH + 1) ? ACC_WIDTH : THRESH_WIDTH + 1;

   localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = 36'd8503680911;
   localparam logic [POS_WIDTH-1:0]    POS_LAST     = POS_WIDTH'(SYMBOL_LEN - 1);

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic signed [COEF_WIDTH-1:0]   coef_type;
   typedef logic signed [PROD_WIDTH-1:0]   prod_type;
   typedef logic signed [ACC_WIDTH-1:0]    acc_type;
   typedef logic signed [CMP_WIDTH-1:0]    cmp_type;
   typedef logic [THRESH_WIDTH-1:0]        thresh_type;
   typedef logic [PHASE_WIDTH-1:0]         phase_type;
   typedef logic [POS_WIDTH-1:0]           pos_type;

   function automatic coef_type cos_coef(input phase_type phase);
      coef_type c;
      unique case (phase)
         3'd0: c = 16'sd32767;
         3'd1: c = 16'sd23170;
         3'd2: c = 16'sd0;
         3'd3: c = -16'sd23170;
         3'd4: c = -16'sd32768;
         3'd5: c = -16'sd23170;
         3'd6: c = 16'sd0;
         3'd7: c = 16'sd23170;
         default: c = 16'sd0;
      endcase
      return c;
   endfunction

   function automatic coef_type nsin_coef(input phase_type phase);
      coef_type c;
      unique case (phase)
         3'd0: c = 16'sd0;
         3'd1: c = -16'sd23170;
         3'd2: c = -16'sd32768;
         3'd3: c = -16'sd23170;
         3'd4: c = 16'sd0;
         3'd5: c = 16'sd23170;
         3'd6: c = 16'sd32767;
         3'd7: c = 16'sd23170;
         default: c = 16'sd0;
      endcase
      return c;
   endfunction

endpackage

// File: sv/qcd_req_if.sv
// ----------------------------------------------------------------------------
// QPSK demodulator sample channel
// Valid/ready channel carrying one bandpass sample per transaction.
// ----------------------------------------------------------------------------
interface qcd_req_if import qcd_pkg::*; ();

   logic       valid;
   logic       ready;
   sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);

endinterface

// File: sv/qcd_rsp_if.sv
// ----------------------------------------------------------------------------
// QPSK demodulator symbol channel
// Valid/ready channel carrying one decided symbol per transaction.
// ----------------------------------------------------------------------------
interface qcd_rsp_if import qcd_pkg::*; ();

   logic valid;
   logic ready;
   logic first_bit;
   logic second_bit;
   logic undetected;

   modport source (output valid, output first_bit, output second_bit, output undetected,
                   input ready);
   modport sink   (input valid, input first_bit, input second_bit, input undetected,
                   output ready);

endinterface

// File: sv/qpsk_coherent_demodulator_unit.sv
// ----------------------------------------------------------------------------
// QPSK coherent demodulator, integrate and dump
// Mixes samples with cosine / negated-sine tables, integrates over a symbol
// and slices the two sums against the energy threshold.
// ----------------------------------------------------------------------------
// Throughput: one sample per clock unless the sample channel stalls; one
// symbol result per 8*SYMBOL_CYCLES samples. The result of a symbol passes
// the input, product, accumulate and slicer registers in turn.
// The sample channel stalls only while a finished symbol waits behind an
// unaccepted one. Reset is synchronous: pipeline and accumulators clear,
// threshold returns to its default.
// ----------------------------------------------------------------------------
module qpsk_coherent_demodulator_unit import qcd_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   qcd_req_if.sink                 req_chan,
   qcd_rsp_if.source               rsp_chan,
   input  logic                    csr_write_enable,
   input  logic [THRESH_WIDTH-1:0] csr_write_data
);

   thresh_type thresh_ff;

   pos_type    pos_ff;
   logic       v1_ff;
   logic       last1_ff;
   phase_type  phase_ff;
   sample_type sample_ff;

   logic       v2_ff;
   logic       last2_ff;
   prod_type   prod_i_ff, prod_q_ff;

   acc_type    acc_i_ff, acc_q_ff;
   acc_type    sum_i_in, sum_q_in;
   logic       v3_ff;
   acc_type    final_i_ff, final_q_ff;

   logic       rsp_valid_ff;
   logic       rsp_first_ff, rsp_second_ff, rsp_undet_ff;

   logic       adv;
   logic       out_load;
   logic       req_take;
   cmp_type    si, sq, tpos, tneg;
   logic       ipos, ineg, qpos, qneg;
   logic       first_in, second_in, undet_in;

   assign adv      = !(v3_ff && rsp_valid_ff && !rsp_chan.ready);
   assign out_load = v3_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && adv;

   assign req_chan.ready      = adv;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.first_bit  = rsp_first_ff;
   assign rsp_chan.second_bit = rsp_second_ff;
   assign rsp_chan.undetected = rsp_undet_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_write_enable) begin
         thresh_ff <= csr_write_data;
      end
   end

   // input register and symbol position
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         v1_ff  <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_chan.valid;
         if (req_chan.valid) begin
            pos_ff <= (pos_ff == POS_LAST) ? '0 : pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         sample_ff <= req_chan.sample;
         phase_ff  <= pos_ff[PHASE_WIDTH-1:0];
         last1_ff  <= (pos_ff == POS_LAST);
      end
   end

   // mixer products
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && v1_ff) begin
         prod_i_ff <= PROD_WIDTH'(sample_ff) * PROD_WIDTH'(cos_coef(phase_ff));
         prod_q_ff <= PROD_WIDTH'(sample_ff) * PROD_WIDTH'(nsin_coef(phase_ff));
         last2_ff  <= last1_ff;
      end
   end

   // integrate and dump
   assign sum_i_in = acc_i_ff + ACC_WIDTH'(prod_i_ff);
   assign sum_q_in = acc_q_ff + ACC_WIDTH'(prod_q_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_i_ff <= '0;
         acc_q_ff <= '0;
         v3_ff    <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff && last2_ff;
         if (v2_ff) begin
            if (last2_ff) begin
               acc_i_ff <= '0;
               acc_q_ff <= '0;
            end else begin
               acc_i_ff <= sum_i_in;
               acc_q_ff <= sum_q_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && v2_ff && last2_ff) begin
         final_i_ff <= sum_i_in;
         final_q_ff <= sum_q_in;
      end
   end

   // slicer
   always_comb begin
      si   = CMP_WIDTH'(final_i_ff);
      sq   = CMP_WIDTH'(final_q_ff);
      tpos = cmp_type'({1'b0, thresh_ff});
      tneg = -tpos;
      ipos = si > tpos;
      ineg = si < tneg;
      qpos = sq > tpos;
      qneg = sq < tneg;
      first_in  = 1'b0;
      second_in = 1'b0;
      undet_in  = 1'b0;
      priority if (ipos && qpos) begin
         first_in  = 1'b0;
         second_in = 1'b0;
      end else if (ipos && qneg) begin
         first_in  = 1'b1;
         second_in = 1'b1;
      end else if (ineg && qpos) begin
         first_in  = 1'b0;
         second_in = 1'b1;
      end else if (ineg && qneg) begin
         first_in  = 1'b1;
         second_in = 1'b0;
      end else begin
         undet_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_first_ff  <= first_in;
         rsp_second_ff <= second_in;
         rsp_undet_ff  <= undet_in;
      end
   end

   // checks
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (v3_ff && rsp_valid_ff))
      else $error("sample channel stalled without a blocked symbol");

   a_pos_wrap: assert property (@(posedge clock) disable iff (reset)
      (req_take && pos_ff == POS_LAST) |=> (pos_ff == '0))
      else $error("symbol position did not wrap");

   a_dump_clear: assert property (@(posedge clock) disable iff (reset)
      (adv && v2_ff && last2_ff) |=> (acc_i_ff == '0 && acc_q_ff == '0 && v3_ff))
      else $error("accumulators not dumped at symbol end");

   a_undet_bits: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_undet_ff) |-> (!rsp_first_ff && !rsp_second_ff))
      else $error("undetected symbol carries bits");

endmodule

// File: bench/qpsk_coherent_demodulator_unit_tb.sv
// ----------------------------------------------------------------------------
// QPSK coherent demodulator unit testbench
// Drives carrier-modulated symbols, noise and spliced symbols into the sample
// channel under bursty traffic and output backpressure, and checks each
// decided symbol against a cycle-free model of the integrate-and-dump slicer
// across several energy threshold settings.
// ----------------------------------------------------------------------------
module qpsk_coherent_demodulator_unit_tb;
   import qcd_pkg::*;

   localparam int SAMPLE_MAX = 2 ** (SAMPLE_WIDTH - 1) - 1;
   localparam int SAMPLE_MIN = -(2 ** (SAMPLE_WIDTH - 1));
   localparam int AMP_MAX    = 23000;
   localparam int RANDOM_ITEMS = 1150;

   typedef struct packed {
      logic first_bit;
      logic second_bit;
      logic undetected;
   } symbol_decision_type;

   typedef enum int {SINK_ALWAYS, SINK_CHOPPY, SINK_BLOCKING} sink_mode_type;

   function automatic int carrier_cos(input int k);
      case (k & 7)
         0: return 32767;
         1: return 23170;
         2: return 0;
         3: return -23170;
         4: return -32768;
         5: return -23170;
         6: return 0;
         default: return 23170;
      endcase
   endfunction

   function automatic int carrier_nsin(input int k);
      case (k & 7)
         0: return 0;
         1: return -23170;
         2: return -32768;
         3: return -23170;
         4: return 0;
         5: return 23170;
         6: return 32767;
         default: return 23170;
      endcase
   endfunction

   class demod_scoreboard;
      thresh_type          threshold;
      int                  position;
      longint              inphase_sum;
      longint              quadrature_sum;
      symbol_decision_type pending_decisions[$];
      int                  mismatches;

      function new();
         threshold      = THRESH_RESET;
         position       = 0;
         inphase_sum    = 0;
         quadrature_sum = 0;
         mismatches     = 0;
      endfunction

      function void set_threshold(input thresh_type t);
         threshold = t;
      endfunction

      function void note_sample(input sample_type s);
         longint              t;
         symbol_decision_type d;
         inphase_sum    += longint'(s) * carrier_cos(position);
         quadrature_sum += longint'(s) * carrier_nsin(position);
         if (position < SYMBOL_LEN - 1) begin
            position++;
         end else begin
            position = 0;
            t = longint'(threshold);
            d = '0;
            if (inphase_sum > t && quadrature_sum > t) begin
               d = '0;
            end else if (inphase_sum > t && quadrature_sum < -t) begin
               d.first_bit  = 1'b1;
               d.second_bit = 1'b1;
            end else if (inphase_sum < -t && quadrature_sum > t) begin
               d.second_bit = 1'b1;
            end else if (inphase_sum < -t && quadrature_sum < -t) begin
               d.first_bit = 1'b1;
            end else begin
               d.undetected = 1'b1;
            end
            pending_decisions.push_back(d);
            inphase_sum    = 0;
            quadrature_sum = 0;
         end
      endfunction

      function void check_symbol(input symbol_decision_type got);
         symbol_decision_type want;
         if (pending_decisions.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected symbol: first_bit=%0b second_bit=%0b undetected=%0b",
                        got.first_bit, got.second_bit, got.undetected);
         end else begin
            want = pending_decisions.pop_front();
            if (got.first_bit !== want.first_bit || got.second_bit !== want.second_bit ||
                got.undetected !== want.undetected) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"symbol mismatch: expected %0b%0b undetected=%0b, ",
                            "got %0b%0b undetected=%0b"},
                           want.first_bit, want.second_bit, want.undetected,
                           got.first_bit, got.second_bit, got.undetected);
            end
         end
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_write_enable = 1'b0;
   thresh_type    csr_write_data = '0;
   logic          sink_ready = 1'b0;
   int            hold_count = 0;
   sink_mode_type sink_mode = SINK_ALWAYS;
   bit            source_bursty = 1'b0;
   int            burst_left = 0;

   demod_scoreboard symbol_board = new();

   qcd_req_if req_chan ();
   qcd_rsp_if rsp_chan ();

   assign rsp_chan.ready = sink_ready;

   qpsk_coherent_demodulator_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (hold_count > 0) begin
         hold_count <= hold_count - 1;
      end else begin
         case (sink_mode)
            SINK_ALWAYS: begin
               sink_ready <= 1'b1;
            end
            SINK_CHOPPY: begin
               sink_ready <= 1'($urandom_range(0, 1));
               hold_count <= $urandom_range(0, 3);
            end
            default: begin
               sink_ready <= !sink_ready;
               hold_count <= sink_ready ? $urandom_range(20, 100) : $urandom_range(0, 12);
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         symbol_board.note_sample(req_chan.sample);
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         symbol_board.check_symbol({rsp_chan.first_bit, rsp_chan.second_bit,
                                    rsp_chan.undetected});
   end

   task automatic push_sample(input sample_type s);
      if (burst_left == 0) begin
         if (source_bursty && $urandom_range(0, 2) != 0) begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_chan.valid  <= 1'b1;
      req_chan.sample <= s;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // one symbol of carrier; amplitudes switch from (ai, aq) to (bi, bq) at cut
   task automatic send_symbol(input int ai, input int aq, input int bi, input int bq,
                              input int cut, input int noise);
      longint v;
      for (int k = 0; k < SYMBOL_LEN; k++) begin
         if (k < cut)
            v = (longint'(ai) * carrier_cos(k) + longint'(aq) * carrier_nsin(k)) >>> 15;
         else
            v = (longint'(bi) * carrier_cos(k) + longint'(bq) * carrier_nsin(k)) >>> 15;
         v += int'($urandom_range(0, 2 * noise)) - noise;
         if (v > SAMPLE_MAX) v = SAMPLE_MAX;
         if (v < SAMPLE_MIN) v = SAMPLE_MIN;
         push_sample(sample_type'(v));
      end
   endtask

   task automatic send_pattern(input sample_type even_value, input sample_type odd_value);
      for (int k = 0; k < SYMBOL_LEN; k++)
         push_sample((k % 2 == 0) ? even_value : odd_value);
   endtask

   // the monitor may not have logged the last transaction yet, so a clock edge passes before the queue is checked
   task automatic settle();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (symbol_board.pending_decisions.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_threshold(input thresh_type t);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= t;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      symbol_board.set_threshold(t);
   endtask

   function automatic int random_amplitude();
      int a;
      a = int'($urandom_range(0, AMP_MAX));
      return ($urandom_range(0, 1) != 0) ? -a : a;
   endfunction

   initial begin
      int         random_items;
      int         roll;
      thresh_type t;
      req_chan.valid  = 1'b0;
      req_chan.sample = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // quadrants, silence and full-scale swing at the default threshold
      send_symbol(20000, 20000, 0, 0, SYMBOL_LEN, 0);
      send_symbol(20000, -20000, 0, 0, SYMBOL_LEN, 0);
      send_symbol(-20000, 20000, 0, 0, SYMBOL_LEN, 0);
      send_symbol(-20000, -20000, 0, 0, SYMBOL_LEN, 0);
      send_pattern('0, '0);
      send_pattern(sample_type'(SAMPLE_MAX), sample_type'(SAMPLE_MIN));

      // constant full negative input integrates to exactly 131072 on both arms
      write_threshold(thresh_type'(131072));
      send_pattern(sample_type'(SAMPLE_MIN), sample_type'(SAMPLE_MIN));
      write_threshold(thresh_type'(131071));
      send_pattern(sample_type'(SAMPLE_MIN), sample_type'(SAMPLE_MIN));

      write_threshold('0);
      send_pattern('0, '0);
      send_pattern(sample_type'(SAMPLE_MAX), sample_type'(SAMPLE_MAX));

      write_threshold('1);
      send_symbol(AMP_MAX, -AMP_MAX, 0, 0, SYMBOL_LEN, 0);

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 5);
         case (roll)
            0: t = THRESH_RESET;
            1: t = '0;
            2: t = '1;
            default: t = thresh_type'({32'($urandom_range(0, 1)), $urandom});
         endcase
         write_threshold(t);
         source_bursty = ($urandom_range(0, 3) != 0);
         sink_mode     = sink_mode_type'($urandom_range(0, 2));
         for (int n = 0; n < 6; n++) begin
            roll = $urandom_range(0, 19);
            if (roll < 14)
               send_symbol(random_amplitude(), random_amplitude(), 0, 0, SYMBOL_LEN,
                           $urandom_range(0, 2000));
            else if (roll < 17)
               send_symbol(0, 0, 0, 0, SYMBOL_LEN, SAMPLE_MAX);
            else
               send_symbol(random_amplitude(), random_amplitude(), random_amplitude(),
                           random_amplitude(), $urandom_range(1, SYMBOL_LEN - 1),
                           $urandom_range(0, 4000));
            random_items += SYMBOL_LEN;
         end
      end

      settle();
      if (symbol_board.mismatches == 0 && symbol_board.pending_decisions.size() == 0)
         $display("qpsk_coherent_demodulator_unit test passed");
      else
         $display("qpsk_coherent_demodulator_unit test failed");
      $finish;
   end

   initial begin
      #20000000;
      $display("qpsk_coherent_demodulator_unit test failed");
      $finish;
   end

endmodule

// File: filelist.f
sv/qcd_pkg.sv
sv/qcd_req_if.sv
sv/qcd_rsp_if.sv
sv/qpsk_coherent_demodulator_unit.sv
bench/qpsk_coherent_demodulator_unit_tb.sv
